// ===== sv/ptg_pkg.sv =====
// ----------------------------------------------------------------------------
// ptg_pkg
// shared types, register codes, key map and tone constants of the tone generator
// ----------------------------------------------------------------------------
package ptg_pkg;

	// default sizes
	localparam int unsigned NOTE_COUNT_DEF  = 13;
	localparam int unsigned SINE_DEPTH_DEF  = 1024;
	localparam int unsigned SAMPLE_RATE_DEF = 48000;

	// field widths
	localparam int unsigned CFG_W     = 31;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned KEY_W     = 8;
	localparam int unsigned KST_W     = 2;
	localparam int unsigned SAMPLE_W  = 32;
	localparam int unsigned MASK_W    = 13;
	localparam int unsigned KEY_NOTES = 13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REL_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd2;

	localparam logic [CFG_W-1:0] SUSTAIN_RST   = 31'd214748364;
	localparam logic [CFG_W-1:0] REL_START_RST = 31'd1048576;
	localparam logic [CFG_W-1:0] DECAY_RST     = 31'd20000;

	// item codes
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;
	localparam logic [KST_W-1:0] KST_RELEASE = 2'd0;
	localparam logic [KST_W-1:0] KST_PRESS   = 2'd1;
	localparam logic [KEY_W-1:0] KEY_NULL    = 8'd0;

	// note frequencies in millihertz, middle c upward
	localparam int unsigned BASE_MHZ [KEY_NOTES] = '{
		261626, 277183, 293665, 311127, 329628, 349228, 369994,
		391995, 415305, 440000, 466164, 493883, 523251
	};

	typedef struct packed {
		logic       hit;
		logic [3:0] note;
	} ptg_key_t;

	// start command from the front end to the note engine
	typedef struct packed {
		logic       go;
		logic       tick;
		logic       sweep;
		logic       press;
		logic       hit;
		logic [3:0] note;
	} ptg_cmd_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} ptg_status_t;

	typedef struct packed {
		logic [CFG_W-1:0] sustain;
		logic [CFG_W-1:0] rel_start;
		logic [CFG_W-1:0] decay;
	} ptg_cfg_t;

	// keyboard row q 2 w 3 e r 5 t 6 y 7 u i
	function automatic ptg_key_t key_to_note(input logic [KEY_W-1:0] code);
		ptg_key_t k;
		k.hit = 1'b1;
		k.note = 4'd0;
		unique case (code)
			8'd16: k.note = 4'd0;
			8'd3:  k.note = 4'd1;
			8'd17: k.note = 4'd2;
			8'd4:  k.note = 4'd3;
			8'd18: k.note = 4'd4;
			8'd19: k.note = 4'd5;
			8'd6:  k.note = 4'd6;
			8'd20: k.note = 4'd7;
			8'd7:  k.note = 4'd8;
			8'd21: k.note = 4'd9;
			8'd8:  k.note = 4'd10;
			8'd22: k.note = 4'd11;
			8'd23: k.note = 4'd12;
			default: k.hit = 1'b0;
		endcase
		return k;
	endfunction

endpackage

// ===== sv/ptg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// ptg_sine_rom
// q1.15 sine table with registered read, contents built at elaboration
// ----------------------------------------------------------------------------
module ptg_sine_rom #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                      clk,
	input  logic [$clog2(DEPTH)-1:0]  addr,
	output logic signed [15:0]        data
);

	localparam logic [63:0] PiQ30    = 64'd3373259426;
	localparam logic [63:0] OneQ30   = 64'd1073741824;
	localparam logic [63:0] TwoDepth = 64'(2 * DEPTH);
	localparam logic [63:0] TaylorDiv [9] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
	};

	// q30 taylor series for 0 <= x <= pi/2
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = '0;
		for (int k = 0; k < 9; k++) begin
			if (k[0] == 1'b0) begin
				sum = sum + signed'(term);
			end else begin
				sum = sum - signed'(term);
			end
			term = ((term * x2) >> 30) / TaylorDiv[k];
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > signed'(OneQ30)) begin
			sum = signed'(OneQ30);
		end
		return unsigned'(sum);
	endfunction

	// quadrant folding, lower half negated
	function automatic logic signed [15:0] sine_entry(input int unsigned i);
		logic [63:0] a;
		logic [63:0] s;
		logic [63:0] v;
		logic        neg;
		a = 64'(i) * 64'd4;
		neg = 1'b0;
		if (a >= TwoDepth) begin
			neg = 1'b1;
			a = a - TwoDepth;
		end
		if (a > 64'(DEPTH)) begin
			a = TwoDepth - a;
		end
		s = sin_q30((a * PiQ30) / TwoDepth);
		v = (s * 64'd32767 + (OneQ30 >> 1)) >> 30;
		return neg ? -signed'(16'(v)) : signed'(16'(v));
	endfunction

	logic signed [15:0] rom [DEPTH];
	logic signed [15:0] data_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign rom[g] = sine_entry(g);
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

	assign data = data_q;

endmodule

// ===== sv/ptg_mul.sv =====
// ----------------------------------------------------------------------------
// ptg_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module ptg_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [16:0] b,
	output logic signed [49:0] prod
);

	logic signed [49:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== sv/ptg_engine.sv =====
// ----------------------------------------------------------------------------
// ptg_engine
// per-note state and the sequencer that walks the notes for ticks and key events
// ----------------------------------------------------------------------------
module ptg_engine
	import ptg_pkg::*;
#(
	parameter int unsigned NOTE_COUNT       = NOTE_COUNT_DEF,
	parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int unsigned SAMPLE_RATE_HZ   = SAMPLE_RATE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ptg_cmd_t                   cmd,
	input  ptg_cfg_t                   cfg,
	input  logic                       take,
	output ptg_status_t                status,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [MASK_W-1:0]          mask
);

	localparam int unsigned NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned AW = 35 + $clog2(NOTE_COUNT);
	localparam logic [NW-1:0] LastNote = NW'(NOTE_COUNT - 1);
	localparam logic [63:0] IncDen = 64'(SAMPLE_RATE_HZ) * 64'd1000;
	localparam logic [63:0] IncRnd = 64'(SAMPLE_RATE_HZ) * 64'd500;

	// notes above the top octave reuse a lower note shifted up
	function automatic logic [31:0] inc_calc(input int unsigned k);
		int unsigned base;
		int unsigned sh;
		logic [63:0] num;
		logic [31:0] r;
		base = k;
		sh = 0;
		for (int j = 0; j < 3; j++) begin
			if (base >= KEY_NOTES) begin
				base = base - 12;
				sh = sh + 1;
			end
		end
		num = (64'(BASE_MHZ[base]) << 32) + IncRnd;
		r = 32'(num / IncDen);
		return r << sh;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ROM,
		ST_MUL,
		ST_ACC,
		ST_SWEEP,
		ST_DONE
	} state_t;

	logic [31:0] inc_tab [NOTE_COUNT];

	for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_inc
		assign inc_tab[g] = inc_calc(g);
	end

	state_t                     state_q;
	logic [NW-1:0]              n_q;
	logic [CFG_W-1:0]           note_vol_q   [NOTE_COUNT];
	logic [CFG_W-1:0]           note_fade_q  [NOTE_COUNT];
	logic [31:0]                note_phase_q [NOTE_COUNT];
	logic [CFG_W-1:0]           cur_vol_q;
	logic signed [AW-1:0]       acc_q;
	logic [MASK_W-1:0]          mask_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       press_q;
	logic                       hit_q;
	logic [3:0]                 note_q;

	logic [CFG_W-1:0]     rd_vol, rd_fade, fd_h, vol_f, fd_f, dec_vol, sw_vol, sw_fade;
	logic [31:0]          rd_phase;
	logic signed [32:0]   mul_a;
	logic signed [16:0]   mul_b;
	logic signed [49:0]   prod;
	logic signed [15:0]   sine;
	logic signed [34:0]   term;
	logic signed [AW-1:0] acc_next;
	logic [SAMPLE_W-1:0]  sat;
	logic [MASK_W-1:0]    mask_next;

	assign rd_vol   = note_vol_q[n_q];
	assign rd_fade  = note_fade_q[n_q];
	assign rd_phase = note_phase_q[n_q];

	// release fade, step halves as the volume closes in on it
	always_comb begin
		fd_h = rd_fade;
		if (rd_vol > rd_fade && {1'b0, rd_vol} < {rd_fade, 1'b0}) begin
			fd_h = rd_fade >> 1;
		end
		if (rd_fade == '0) begin
			vol_f = rd_vol;
			fd_f = '0;
		end else if (rd_vol <= fd_h) begin
			vol_f = '0;
			fd_f = '0;
		end else begin
			vol_f = rd_vol - fd_h;
			fd_f = fd_h;
		end
	end

	// natural decay
	always_comb begin
		if (cur_vol_q > cfg.decay) begin
			dec_vol = cur_vol_q - cfg.decay;
		end else if (cur_vol_q != '0) begin
			dec_vol = cur_vol_q - CFG_W'(1);
		end else begin
			dec_vol = '0;
		end
	end

	// key event on one note, then re-sustain
	always_comb begin
		sw_vol = rd_vol;
		sw_fade = rd_fade;
		if (hit_q && 6'(n_q) == 6'(note_q)) begin
			if (press_q) begin
				sw_vol = CFG_W'(1);
				sw_fade = '0;
			end else begin
				sw_fade = cfg.rel_start;
			end
		end
		if (sw_vol != '0 && sw_fade == '0) begin
			sw_vol = cfg.sustain;
		end
	end

	// multiplier: phase to table index, then volume times sine
	assign mul_a = (state_q == ST_FETCH) ? signed'({1'b0, rd_phase})
	                                     : signed'({2'b00, cur_vol_q});
	assign mul_b = (state_q == ST_FETCH) ? signed'(17'(SINE_TABLE_DEPTH))
	                                     : signed'({sine[15], sine});

	ptg_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ptg_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (prod[32 +: IW]),
		.data (sine)
	);

	assign term     = prod[49:15];
	assign acc_next = acc_q + AW'(term);

	always_comb begin
		if (acc_next[AW-1:31] == '0 || acc_next[AW-1:31] == '1) begin
			sat = acc_next[31:0];
		end else if (acc_next[AW-1]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = 32'h7fff_ffff;
		end
	end

	assign mask_next = mask_q | ((dec_vol != '0 && 6'(n_q) < 6'(KEY_NOTES))
	                             ? (MASK_W'(1) << n_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			cur_vol_q <= '0;
			acc_q <= '0;
			mask_q <= '0;
			sample_q <= '0;
			press_q <= 1'b0;
			hit_q <= 1'b0;
			note_q <= '0;
			for (int i = 0; i < NOTE_COUNT; i++) begin
				note_vol_q[i] <= '0;
				note_fade_q[i] <= '0;
				note_phase_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					n_q <= '0;
					acc_q <= '0;
					mask_q <= '0;
					press_q <= cmd.press;
					hit_q <= cmd.hit;
					note_q <= cmd.note;
					if (cmd.go && cmd.tick) begin
						state_q <= ST_FETCH;
					end else if (cmd.go && cmd.sweep) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_FETCH: begin
					note_fade_q[n_q] <= fd_f;
					cur_vol_q <= vol_f;
					state_q <= ST_ROM;
				end
				ST_ROM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					note_vol_q[n_q] <= dec_vol;
					note_phase_q[n_q] <= (dec_vol != '0) ? rd_phase + inc_tab[n_q] : '0;
					acc_q <= acc_next;
					mask_q <= mask_next;
					if (n_q == LastNote) begin
						sample_q <= signed'(sat);
						state_q <= ST_DONE;
					end else begin
						n_q <= n_q + NW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_SWEEP: begin
					note_vol_q[n_q] <= sw_vol;
					note_fade_q[n_q] <= sw_fade;
					if (n_q == LastNote) begin
						state_q <= ST_IDLE;
					end else begin
						n_q <= n_q + NW'(1);
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign status.busy      = (state_q != ST_IDLE);
	assign status.res_valid = (state_q == ST_DONE);
	assign sample           = sample_q;
	assign mask             = mask_q;

endmodule

// ===== sv/polyphonic_tone_generator_unit.sv =====
// ----------------------------------------------------------------------------
// polyphonic_tone_generator_unit
// tick: four steps per note on one shared multiplier (table index, table read,
//   volume product, accumulate), the result then held until it is taken
// next item: taken the cycle after the result moves into the output register;
//   no item is taken while a tick is in flight or its result is held
// key event: re-sustain sweep over every note, next item once the sweep ends;
//   null code or ignored states leave the engine idle, next item the following cycle
// reset: all note volume, fade and phase state cleared at once, config to defaults
// ----------------------------------------------------------------------------
module polyphonic_tone_generator_unit
	import ptg_pkg::*;
#(
	parameter int unsigned NOTE_COUNT       = NOTE_COUNT_DEF,
	parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int unsigned SAMPLE_RATE_HZ   = SAMPLE_RATE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [KEY_W-1:0]           scan_code,
	input  logic [KST_W-1:0]           key_state,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] audio_sample,
	output logic [MASK_W-1:0]          notes_sounding
);

	ptg_cfg_t                   cfg_q;
	ptg_cmd_t                   eng_cmd;
	ptg_status_t                eng_status;
	ptg_key_t                   key;
	logic                       in_accept;
	logic                       out_load;
	logic signed [SAMPLE_W-1:0] eng_sample;
	logic [MASK_W-1:0]          eng_mask;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] audio_sample_q;
	logic [MASK_W-1:0]          notes_q;

	// config registers, writes past the last index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sustain <= SUSTAIN_RST;
			cfg_q.rel_start <= REL_START_RST;
			cfg_q.decay <= DECAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SUSTAIN:   cfg_q.sustain <= cfg_data;
				CFG_REL_START: cfg_q.rel_start <= cfg_data;
				CFG_DECAY:     cfg_q.decay <= cfg_data;
				default: ;
			endcase
		end
	end

	// engine busy covers a held result, so stall is straight from a flop
	assign in_stall  = eng_status.busy;
	assign in_accept = in_valid && !in_stall;

	// decode the item into a start command
	assign key = key_to_note(scan_code);

	always_comb begin
		eng_cmd.go = in_accept;
		eng_cmd.tick = (cmd == CMD_TICK);
		// only a real press or release with a non-null code touches note state
		eng_cmd.sweep = (cmd == CMD_EVENT) && (scan_code != KEY_NULL)
			&& (key_state == KST_PRESS || key_state == KST_RELEASE);
		eng_cmd.press = (key_state == KST_PRESS);
		eng_cmd.hit = key.hit;
		eng_cmd.note = key.note;
	end

	ptg_engine #(
		.NOTE_COUNT       (NOTE_COUNT),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.SAMPLE_RATE_HZ   (SAMPLE_RATE_HZ)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (eng_cmd),
		.cfg    (cfg_q),
		.take   (out_load),
		.status (eng_status),
		.sample (eng_sample),
		.mask   (eng_mask)
	);

	// output register, refilled as the previous item leaves
	assign out_load = eng_status.res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			audio_sample_q <= eng_sample;
			notes_q <= eng_mask;
		end
	end

	assign out_valid      = out_valid_q;
	assign audio_sample   = audio_sample_q;
	assign notes_sounding = notes_q;

	// a tick always keeps the engine occupied past the accepting edge
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && cmd == CMD_TICK |=> eng_status.busy)
		else $error("tick accepted but engine idle");

	// key events never produce a result right away
	a_event_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && cmd == CMD_EVENT |=> !eng_status.res_valid)
		else $error("key event produced a result");

	// a new result shows up only from a finished engine pass
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(eng_status.res_valid))
		else $error("output without engine result");

	// no sounding bit for notes that do not exist
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (notes_q >> NOTE_COUNT) == '0)
		else $error("sounding bit beyond note count");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the polyphonic tone generator: key events and sample
// ticks go in through the valid/stall port, a scoreboard class keeps its own
// model of every note (volume, fade step, phase) and checks each mixed sample
// and its sounding-note mask, while both sides idle and stall at random
// ----------------------------------------------------------------------------
module testbench;
	import ptg_pkg::*;

	// block sizes, kept at the defaults of the unit
	localparam int unsigned TONES      = NOTE_COUNT_DEF;
	localparam int unsigned SINE_DEPTH = SINE_DEPTH_DEF;
	localparam int unsigned RATE_HZ    = SAMPLE_RATE_DEF;

	// fixed-point constants for building the sine lookup
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	localparam longint SAMPLE_MAX = 64'sd2147483647;
	localparam longint SAMPLE_MIN = -64'sd2147483648;

	// key states that the unit must ignore
	localparam logic [KST_W-1:0] KEY_AUTOREPEAT = 2'd2;
	localparam logic [KST_W-1:0] KEY_UNUSED     = 2'd3;

	// keyboard row q 2 w 3 e r 5 t 6 y 7 u i, note 0 upward
	localparam logic [KEY_W-1:0] KEY_ROW [KEY_NOTES] = '{
		8'd16, 8'd3, 8'd17, 8'd4, 8'd18, 8'd19, 8'd6,
		8'd20, 8'd7, 8'd21, 8'd8, 8'd22, 8'd23
	};

	// register settings per phase: defaults, short notes, all high,
	// loud with a slow fade and no decay, all zero, tiny values that halve the fade
	localparam int PHASES = 6;
	localparam logic [CFG_W-1:0] SUSTAIN_SET [PHASES] = '{
		SUSTAIN_RST, 31'd200000, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd0, 31'd5
	};
	localparam logic [CFG_W-1:0] RELEASE_SET [PHASES] = '{
		REL_START_RST, 31'd40000, 31'h7FFFFFFF, 31'd1, 31'd0, 31'd3
	};
	localparam logic [CFG_W-1:0] DECAY_SET [PHASES] = '{
		DECAY_RST, 31'd20000, 31'h7FFFFFFF, 31'd0, 31'd0, 31'd1
	};
	localparam int RANDOM_ITEMS [PHASES] = '{150, 120, 100, 110, 40, 80};

	// settle time after the last sample before touching the registers, long
	// enough for a tick or a key sweep in the unit to finish
	localparam int     ENGINE_SETTLE = 70;
	localparam int     LONG_HOLD     = 400;
	localparam int     MAX_REPORTS   = 10;
	localparam longint TIMEOUT_NS    = 64'd8000000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [MASK_W-1:0]          notes;
	} tone_result_t;

	// ------------------------------------------------------------------------
	// scoreboard: per-note synth state, queue of predicted samples
	// ------------------------------------------------------------------------
	class tone_scoreboard;
		int           sine_lut [SINE_DEPTH];
		int unsigned  step_inc [TONES];
		int unsigned  volume [TONES];
		int unsigned  fade [TONES];
		int unsigned  phase [TONES];
		int unsigned  sustain;
		int unsigned  rel_start;
		int unsigned  decay;
		tone_result_t pending_samples [$];
		int unsigned  mismatches;

		function new();
			longint unsigned d;
			longint unsigned a, x, x2, term, s, v;
			longint          sum;
			bit              neg;
			int              i, n;
			d = SINE_DEPTH;
			// quarter-wave folding plus a q30 taylor series, negated in the lower half
			for (i = 0; i < SINE_DEPTH; i++) begin
				a = 4 * i;
				neg = 1'b0;
				if (a >= 2 * d) begin
					neg = 1'b1;
					a -= 2 * d;
				end
				if (a > d)
					a = 2 * d - a;
				x = (a * PI_Q30) / (2 * d);
				x2 = (x * x) >> 30;
				term = x;
				sum = 0;
				for (n = 1; n <= 17; n += 2) begin
					if (((n >> 1) & 1) == 0)
						sum += signed'(term);
					else
						sum -= signed'(term);
					term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
				end
				if (sum < 0)
					sum = 0;
				if (sum > signed'(ONE_Q30))
					sum = signed'(ONE_Q30);
				s = unsigned'(sum);
				v = (s * 32767 + (ONE_Q30 >> 1)) >> 30;
				sine_lut[i] = neg ? -int'(v) : int'(v);
			end
			for (i = 0; i < TONES; i++)
				step_inc[i] = int'(((longint'(BASE_MHZ[i]) << 32) + 500 * longint'(RATE_HZ))
					/ (1000 * longint'(RATE_HZ)));
			sustain   = SUSTAIN_RST;
			rel_start = REL_START_RST;
			decay     = DECAY_RST;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_SUSTAIN:   sustain = val;
				CFG_REL_START: rel_start = val;
				CFG_DECAY:     decay = val;
				default: ;
			endcase
		endfunction

		// update the note state for one accepted item, queue a sample on a tick
		function void take_item(logic c, logic [KEY_W-1:0] code, logic [KST_W-1:0] st);
			longint          acc, prod;
			longint unsigned idx;
			int unsigned     v, f;
			logic [MASK_W-1:0] msk;
			tone_result_t    r;
			int              n, hit;
			if (c == CMD_TICK) begin
				acc = 0;
				msk = '0;
				for (n = 0; n < TONES; n++) begin
					v = volume[n];
					f = fade[n];
					if (f != 0) begin
						if (v > f && {32'd0, v} < {31'd0, f, 1'b0})
							f = f / 2;
						if (v <= f) begin
							v = 0;
							f = 0;
						end else begin
							v -= f;
						end
						fade[n] = f;
					end
					idx = ({32'd0, phase[n]} * SINE_DEPTH) >> 32;
					prod = signed'({32'd0, v}) * longint'(sine_lut[idx]);
					acc += prod >>> 15;
					if (v > decay)
						v -= decay;
					else if (v > 0)
						v -= 1;
					volume[n] = v;
					if (v != 0) begin
						phase[n] += step_inc[n];
						if (n < MASK_W)
							msk[n] = 1'b1;
					end else begin
						phase[n] = 0;
					end
				end
				if (acc > SAMPLE_MAX)
					acc = SAMPLE_MAX;
				if (acc < SAMPLE_MIN)
					acc = SAMPLE_MIN;
				r.sample = acc[SAMPLE_W-1:0];
				r.notes = msk;
				pending_samples.push_back(r);
				return;
			end
			if (st != KST_PRESS && st != KST_RELEASE)
				return;
			hit = -1;
			for (n = 0; n < KEY_NOTES; n++)
				if (KEY_ROW[n] == code)
					hit = n;
			if (hit >= 0 && hit < TONES) begin
				if (st == KST_PRESS) begin
					volume[hit] = 1;
					fade[hit] = 0;
				end else begin
					fade[hit] = rel_start;
				end
			end
			if (code == KEY_NULL)
				return;
			// any real key brings every freely decaying note back to sustain
			for (n = 0; n < TONES; n++)
				if (volume[n] != 0 && fade[n] == 0)
					volume[n] = sustain;
		endfunction

		function void check_sample(logic signed [SAMPLE_W-1:0] sample, logic [MASK_W-1:0] notes);
			tone_result_t want;
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected sample %0d notes %h", $time, sample, notes);
				return;
			end
			want = pending_samples.pop_front();
			if (sample !== want.sample || notes !== want.notes) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: sample exp %0d got %0d, notes exp %h got %h", $time,
						want.sample, sample, want.notes, notes);
			end
		endfunction

		function int outstanding();
			return pending_samples.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals and the unit
	// ------------------------------------------------------------------------
	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic                       cmd;
	logic [KEY_W-1:0]           scan_code;
	logic [KST_W-1:0]           key_state;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] audio_sample;
	logic [MASK_W-1:0]          notes_sounding;

	tone_scoreboard sb;

	// calm switches idling off on both sides, long_hold asks for one long output stall
	bit calm;
	bit long_hold;

	polyphonic_tone_generator_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.scan_code      (scan_code),
		.key_state      (key_state),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.audio_sample   (audio_sample),
		.notes_sounding (notes_sounding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly short, now and then a long stretch
	function automatic int unsigned stretch_len();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	// offer one item, hold it until the unit takes it, then update the model
	task automatic send_item(input logic c, input logic [KEY_W-1:0] code,
			input logic [KST_W-1:0] st);
		int unsigned gap;
		gap = (!calm && $urandom_range(0, 2) == 0) ? stretch_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		scan_code <= code;
		key_state <= st;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.take_item(c, code, st);
	endtask

	// stop sending, wait for every sample, then let the note engine go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (ENGINE_SETTLE) @(posedge clk);
	endtask

	// write all three registers back to back, unit idle
	task automatic program_regs(input int ph);
		logic [CFG_IDX_W-1:0] idx_list [3];
		logic [CFG_W-1:0]     val_list [3];
		int i;
		idx_list = '{CFG_SUSTAIN, CFG_REL_START, CFG_DECAY};
		val_list = '{SUSTAIN_SET[ph], RELEASE_SET[ph], DECAY_SET[ph]};
		for (i = 0; i < 3; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data  <= val_list[i];
			@(posedge clk);
			sb.set_reg(idx_list[i], val_list[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly ticks and presses/releases of mapped keys, plus unmapped,
	// null-code, autorepeat and unused-state noise
	task automatic random_item();
		int unsigned      pick;
		logic [KEY_W-1:0] code;
		logic [KST_W-1:0] st;
		pick = $urandom_range(0, 99);
		code = KEY_ROW[$urandom_range(0, KEY_NOTES - 1)];
		st = KST_W'($urandom_range(0, 3));
		if (pick < 50)
			send_item(CMD_TICK, KEY_W'($urandom), st);
		else if (pick < 80)
			send_item(CMD_EVENT, code,
				($urandom_range(0, 4) < 3) ? KST_PRESS : KST_RELEASE);
		else if (pick < 88)
			send_item(CMD_EVENT, KEY_W'($urandom), st);
		else if (pick < 94)
			send_item(CMD_EVENT, KEY_NULL, st);
		else
			send_item(CMD_EVENT, code,
				($urandom_range(0, 1) != 0) ? KEY_AUTOREPEAT : KEY_UNUSED);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int ph, i;
		sb = new();
		calm      = 1'b0;
		long_hold = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_SUSTAIN;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		cmd       <= CMD_EVENT;
		scan_code <= KEY_NULL;
		key_state <= KST_RELEASE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph < PHASES; ph++) begin
			// the sender waits here until every sample has come back
			if (ph != 0)
				settle();
			program_regs(ph);

			if (ph == 0) begin
				// lowest and highest notes of the keyboard
				send_item(CMD_EVENT, KEY_ROW[0], KST_PRESS);
				send_item(CMD_EVENT, KEY_ROW[KEY_NOTES-1], KST_PRESS);
				send_item(CMD_TICK, KEY_NULL, KST_RELEASE);
				send_item(CMD_TICK, KEY_NULL, KST_RELEASE);
				// unmapped code still re-sustains, null code does nothing
				send_item(CMD_EVENT, 8'hFF, KST_PRESS);
				send_item(CMD_EVENT, KEY_NULL, KST_PRESS);
				send_item(CMD_EVENT, KEY_NULL, KST_RELEASE);
				// autorepeat and the unused state are ignored
				send_item(CMD_EVENT, KEY_ROW[0], KEY_AUTOREPEAT);
				send_item(CMD_EVENT, KEY_ROW[0], KEY_UNUSED);
				// tick with every payload bit set
				send_item(CMD_TICK, 8'hFF, KEY_UNUSED);
				// releases start the fade
				send_item(CMD_EVENT, KEY_ROW[0], KST_RELEASE);
				send_item(CMD_TICK, KEY_NULL, KST_RELEASE);
				send_item(CMD_EVENT, KEY_ROW[KEY_NOTES-1], KST_RELEASE);
				send_item(CMD_TICK, KEY_NULL, KST_PRESS);
				// release of a note that never sounded
				send_item(CMD_EVENT, KEY_ROW[1], KST_RELEASE);
				send_item(CMD_TICK, KEY_NULL, KST_RELEASE);
				// press after a release cancels the fade
				send_item(CMD_EVENT, KEY_ROW[10], KST_PRESS);
				send_item(CMD_EVENT, KEY_ROW[0], KST_PRESS);
				send_item(CMD_TICK, KEY_NULL, KST_RELEASE);
				send_item(CMD_TICK, KEY_NULL, KST_RELEASE);
			end

			for (i = 0; i < RANDOM_ITEMS[ph]; i++) begin
				// a stretch with no idling on either side
				calm = (i >= 40 && i < 70);
				// one long output stall while items keep coming, fills the unit
				if (ph == 1 && i == 20)
					long_hold = 1'b1;
				random_item();
			end
			calm = 1'b0;
		end

		settle();
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// output stall: random stalls, quiet stretches and the one long hold
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (stretch_len()) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// every sample taken by the bench goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_sample(audio_sample, notes_sounding);
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ptg_pkg.sv
sv/ptg_sine_rom.sv
sv/ptg_mul.sv
sv/ptg_engine.sv
sv/polyphonic_tone_generator_unit.sv
bench/testbench.sv
